// ----- rtl/wdmm_pkg.sv -----
package wdmm_pkg;

  localparam int unsigned NumStats = 24;
  localparam int unsigned SqWidth = 40;
  localparam logic [SqWidth-1:0] SqMax = {SqWidth{1'b1}};

  typedef enum logic [4:0] {
    StTempMin = 5'd0, StTempMax = 5'd1, StPressMin = 5'd2, StPressMax = 5'd3,
    StPlotTempMin = 5'd4, StPlotTempMax = 5'd5, StCurveMin = 5'd6, StCurveMax = 5'd7,
    StTempSum = 5'd8, StTempSq = 5'd9, StTempCnt = 5'd10,
    StHumSum = 5'd11, StHumSq = 5'd12, StHumCnt = 5'd13,
    StPressSum = 5'd14, StPressSq = 5'd15, StPressCnt = 5'd16,
    StTempFirst = 5'd17, StTempLast = 5'd18, StHumFirst = 5'd19, StHumLast = 5'd20,
    StPressFirst = 5'd21, StPressLast = 5'd22, StPoints = 5'd23
  } stat_e;

  typedef enum logic [2:0] {
    RegWinStart = 3'd0, RegWinEnd = 3'd1, RegDecim = 3'd2,
    RegCurve = 3'd3, RegPressOn = 3'd4, RegMissing = 3'd5
  } reg_e;

  localparam logic [1:0] CurveHum = 2'd1;
  localparam logic [1:0] CurvePress = 2'd2;

  // One extreme slot: value, time and whether it ever got a value.
  typedef struct packed {
    logic               valid;
    logic signed [15:0] value;
    logic [31:0]        time_s;
  } ext_t;

  // One accumulated channel.
  typedef struct packed {
    logic signed [39:0] sum;
    logic [SqWidth-1:0] sq;
    logic               first_v;
    logic signed [15:0] first;
    logic signed [15:0] last_val;
  } acc_t;

  // Statistics snapshot handed to the output sequencer.
  typedef struct packed {
    ext_t [7:0]  ext;
    logic [7:0]  min_idx;
    logic [7:0]  max_idx;
    acc_t [2:0]  acc;
  } snap_t;

endpackage

// ----- rtl/windowed_decimating_min_max_stats.sv -----
// A sample word passes the input register and then the point output register.
// One sample word is taken per cycle while in_stall_o is low.
// A finish word emits 24 statistic words from a snapshot, one per cycle while
// unstalled, after any pending point; later input words wait until the run drains.
// Reset clears all statistics and restores register defaults.
module windowed_decimating_min_max_stats #(
  parameter int unsigned POINT_CAPACITY = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               mode_i,
  input  logic [31:0]        timestamp_i,
  input  logic signed [15:0] temp_code_i,
  input  logic signed [15:0] hum_code_i,
  input  logic signed [15:0] press_code_i,
  input  logic               hum_present_i,
  input  logic               press_present_i,
  input  logic               is_newest_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               kind_o,
  output logic [7:0]         point_index_o,
  output logic [31:0]        point_time_o,
  output logic signed [15:0] curve_one_o,
  output logic               curve_one_valid_o,
  output logic signed [15:0] curve_two_o,
  output logic               curve_two_valid_o,
  output logic [4:0]         stat_code_o,
  output logic signed [63:0] stat_value_o,
  output logic               stat_valid_o,
  output logic               last_o
);
  import wdmm_pkg::*;

  localparam int unsigned CntW = $clog2(POINT_CAPACITY + 1);

  // Registers.
  logic [31:0]        win_start_q, win_end_q;
  logic [5:0]         decim_q;
  logic [1:0]         curve_q;
  logic               press_on_q;
  logic signed [15:0] missing_q;

  // Input stage.
  logic               in_v_q, in_mode_q, in_hp_q, in_pp_q, in_new_q;
  logic [31:0]        in_t_q;
  logic signed [15:0] in_tc_q, in_hc_q, in_pc_q;

  // State.
  snap_t              st_q, st_d;
  logic [5:0]         phase_q, phase_d;
  logic [CntW-1:0]    pts_q, pts_d;
  logic [CntW-1:0]    cnt_q [3];
  logic [CntW-1:0]    cnt_d [3];

  // Point output register.
  logic               pv_q;
  logic [7:0]         p_idx_q;
  logic [31:0]        p_t_q;
  logic signed [15:0] p_c1_q, p_c2_q;
  logic               p_c1v_q, p_c2v_q;

  logic [5:0] eff_dec;
  logic       proceed, fin, start, samp, in_win, tok, hok, pok, pick, c2ok;
  logic       add_t, add_h, add_p;
  logic signed [15:0] c2;
  logic       emit_busy, emit_take, e_sv, e_vld, e_last;
  logic [4:0] e_code;
  logic [7:0] e_idx;
  logic [31:0] e_time;
  logic signed [63:0] e_val;
  acc_t       acc_n [3];

  assign eff_dec = (decim_q == '0) ? 6'd1 : decim_q;

  // The input register advances unless a point waits on a stalled output or it
  // holds a word while a statistics run is still draining.
  assign proceed = !(pv_q && out_stall_i) && !(in_v_q && emit_busy);
  assign in_stall_o = !proceed;
  assign fin = in_v_q && in_mode_q;
  assign start = fin && proceed;
  assign samp = in_v_q && !in_mode_q && proceed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_start_q <= '0;
      win_end_q <= '1;
      decim_q <= 6'd1;
      curve_q <= '0;
      press_on_q <= 1'b0;
      missing_q <= 16'sh8000;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegWinStart: win_start_q <= cfg_data_i;
        RegWinEnd:   win_end_q <= cfg_data_i;
        RegDecim:    decim_q <= cfg_data_i[5:0];
        RegCurve:    curve_q <= cfg_data_i[1:0];
        RegPressOn:  press_on_q <= cfg_data_i[0];
        RegMissing:  missing_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (proceed) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proceed && in_valid_i) begin
      in_mode_q <= mode_i;
      in_t_q <= timestamp_i;
      in_tc_q <= temp_code_i;
      in_hc_q <= hum_code_i;
      in_pc_q <= press_code_i;
      in_hp_q <= hum_present_i;
      in_pp_q <= press_present_i;
      in_new_q <= is_newest_i;
    end
  end

  assign in_win = in_t_q >= win_start_q && in_t_q <= win_end_q
                  && pts_q < CntW'(POINT_CAPACITY);
  assign tok = in_tc_q != missing_q;
  assign hok = in_hp_q && in_hc_q != missing_q;
  assign pok = in_pp_q && in_pc_q != missing_q;
  assign pick = (32'(phase_q) + 32'd1 >= 32'(eff_dec)) || in_new_q;
  assign c2ok = (curve_q == CurveHum) ? hok : (curve_q == CurvePress) ? pok : 1'b0;
  assign c2 = !c2ok ? 16'sd0 : (curve_q == CurveHum) ? in_hc_q : in_pc_q;
  assign add_t = samp && in_win && pick && tok;
  assign add_h = samp && in_win && pick && curve_q == CurveHum && hok;
  assign add_p = samp && in_win && pick && press_on_q && pok;

  wdmm_acc u_acc_t (.add_i(add_t), .v_i(in_tc_q), .cur_i(st_q.acc[0]), .nxt_o(acc_n[0]));
  wdmm_acc u_acc_h (.add_i(add_h), .v_i(in_hc_q), .cur_i(st_q.acc[1]), .nxt_o(acc_n[1]));
  wdmm_acc u_acc_p (.add_i(add_p), .v_i(in_pc_q), .cur_i(st_q.acc[2]), .nxt_o(acc_n[2]));

  always_comb begin
    st_d = st_q;
    phase_d = phase_q;
    pts_d = pts_q;
    cnt_d = cnt_q;
    if (samp && in_win) begin
      if (tok) begin
        if (!st_q.ext[0].valid || in_tc_q < st_q.ext[0].value)
          st_d.ext[0] = '{1'b1, in_tc_q, in_t_q};
        if (!st_q.ext[1].valid || in_tc_q > st_q.ext[1].value)
          st_d.ext[1] = '{1'b1, in_tc_q, in_t_q};
      end
      if (pok) begin
        if (!st_q.ext[2].valid || in_pc_q < st_q.ext[2].value)
          st_d.ext[2] = '{1'b1, in_pc_q, in_t_q};
        if (!st_q.ext[3].valid || in_pc_q > st_q.ext[3].value)
          st_d.ext[3] = '{1'b1, in_pc_q, in_t_q};
      end
      phase_d = (32'(phase_q) + 32'd1 >= 32'(eff_dec)) ? 6'd0 : phase_q + 6'd1;
      if (pick) begin
        if (tok) begin
          if (!st_q.ext[4].valid || in_tc_q < st_q.ext[4].value) begin
            st_d.ext[4] = '{1'b1, in_tc_q, in_t_q};
            st_d.min_idx = 8'(pts_q);
          end
          if (!st_q.ext[5].valid || in_tc_q > st_q.ext[5].value) begin
            st_d.ext[5] = '{1'b1, in_tc_q, in_t_q};
            st_d.max_idx = 8'(pts_q);
          end
        end
        if (c2ok) begin
          if (!st_q.ext[6].valid || c2 < st_q.ext[6].value)
            st_d.ext[6] = '{1'b1, c2, in_t_q};
          if (!st_q.ext[7].valid || c2 > st_q.ext[7].value)
            st_d.ext[7] = '{1'b1, c2, in_t_q};
        end
        pts_d = pts_q + CntW'(1);
      end
    end
    st_d.acc[0] = acc_n[0];
    st_d.acc[1] = acc_n[1];
    st_d.acc[2] = acc_n[2];
    if (add_t) cnt_d[0] = cnt_q[0] + CntW'(1);
    if (add_h) cnt_d[1] = cnt_q[1] + CntW'(1);
    if (add_p) cnt_d[2] = cnt_q[2] + CntW'(1);
    if (start) begin
      st_d = '0;
      phase_d = eff_dec - 6'd1;
      pts_d = '0;
      cnt_d[0] = '0;
      cnt_d[1] = '0;
      cnt_d[2] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
      phase_q <= '0;
      pts_q <= '0;
      cnt_q[0] <= '0;
      cnt_q[1] <= '0;
      cnt_q[2] <= '0;
      pv_q <= 1'b0;
    end else begin
      st_q <= st_d;
      phase_q <= (cfg_we_i && cfg_index_i == RegDecim)
                 ? ((cfg_data_i[5:0] == '0) ? 6'd0 : cfg_data_i[5:0] - 6'd1) : phase_d;
      pts_q <= pts_d;
      cnt_q <= cnt_d;
      if (!(pv_q && out_stall_i)) pv_q <= samp && in_win && pick;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!(pv_q && out_stall_i)) begin
      p_idx_q <= 8'(pts_q);
      p_t_q <= in_t_q;
      p_c1_q <= tok ? in_tc_q : 16'sd0;
      p_c1v_q <= tok;
      p_c2_q <= c2;
      p_c2v_q <= c2ok;
    end
  end

  // Points have priority; the statistics run waits until the point slot is empty.
  assign emit_take = !pv_q && !out_stall_i;

  wdmm_emit #(.CntW(CntW)) u_emit (
    .clk_i, .rst_ni,
    .start_i(start),
    .snap_i(st_q),
    .pts_i(pts_q),
    .cnt0_i(cnt_q[0]), .cnt1_i(cnt_q[1]), .cnt2_i(cnt_q[2]),
    .take_i(emit_take),
    .busy_o(emit_busy),
    .sv_o(e_sv), .code_o(e_code), .idx_o(e_idx), .time_o(e_time),
    .val_o(e_val), .vld_o(e_vld), .last_o(e_last)
  );

  assign out_valid_o = pv_q || e_sv;
  assign kind_o = !pv_q;
  assign point_index_o = pv_q ? p_idx_q : e_idx;
  assign point_time_o = pv_q ? p_t_q : e_time;
  assign curve_one_o = pv_q ? p_c1_q : 16'sd0;
  assign curve_one_valid_o = pv_q && p_c1v_q;
  assign curve_two_o = pv_q ? p_c2_q : 16'sd0;
  assign curve_two_valid_o = pv_q && p_c2v_q;
  assign stat_code_o = pv_q ? 5'd0 : e_code;
  assign stat_value_o = pv_q ? 64'sd0 : e_val;
  assign stat_valid_o = !pv_q && e_vld;
  assign last_o = !pv_q && e_last;

endmodule

// ----- rtl/wdmm_acc.sv -----
module wdmm_acc (
  input  logic               add_i,
  input  logic signed [15:0] v_i,
  input  wdmm_pkg::acc_t     cur_i,
  output wdmm_pkg::acc_t     nxt_o
);
  import wdmm_pkg::*;

  logic signed [31:0] vx;
  logic [31:0]        sq;
  logic [SqWidth:0]   sqsum;

  always_comb begin
    vx = 32'(v_i);
    sq = 32'(vx * vx);
    sqsum = {1'b0, cur_i.sq} + {9'd0, sq};
    nxt_o = cur_i;
    if (add_i) begin
      nxt_o.sum = cur_i.sum + 40'(v_i);
      nxt_o.sq = sqsum[SqWidth] ? SqMax : sqsum[SqWidth-1:0];
      if (!cur_i.first_v) begin
        nxt_o.first_v = 1'b1;
        nxt_o.first = v_i;
      end
      nxt_o.last_val = v_i;
    end
  end

endmodule

// ----- rtl/wdmm_emit.sv -----
module wdmm_emit #(
  parameter int unsigned CntW = 9
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  wdmm_pkg::snap_t    snap_i,
  input  logic [CntW-1:0]    pts_i,
  input  logic [CntW-1:0]    cnt0_i,
  input  logic [CntW-1:0]    cnt1_i,
  input  logic [CntW-1:0]    cnt2_i,
  input  logic               take_i,
  output logic               busy_o,
  output logic               sv_o,
  output logic [4:0]         code_o,
  output logic [7:0]         idx_o,
  output logic [31:0]        time_o,
  output logic signed [63:0] val_o,
  output logic               vld_o,
  output logic               last_o
);
  import wdmm_pkg::*;

  snap_t           snap_q;
  logic [CntW-1:0] pts_q;
  logic [CntW-1:0] cnt_q [3];
  logic [4:0]      code_q;
  logic            busy_q;
  logic [1:0]      ch;
  logic [4:0]      rel;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      snap_q <= snap_i;
      pts_q <= pts_i;
      cnt_q[0] <= cnt0_i;
      cnt_q[1] <= cnt1_i;
      cnt_q[2] <= cnt2_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      code_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      code_q <= '0;
    end else if (busy_q && take_i) begin
      if (code_q == StPoints) busy_q <= 1'b0;
      code_q <= code_q + 5'd1;
    end
  end

  always_comb begin
    idx_o = '0;
    time_o = '0;
    val_o = '0;
    vld_o = 1'b0;
    ch = '0;
    rel = '0;
    if (code_q < StTempSum) begin
      time_o = snap_q.ext[code_q[2:0]].time_s;
      vld_o = snap_q.ext[code_q[2:0]].valid;
      val_o = vld_o ? 64'(snap_q.ext[code_q[2:0]].value) : '0;
      if (code_q == StPlotTempMin) idx_o = snap_q.min_idx;
      if (code_q == StPlotTempMax) idx_o = snap_q.max_idx;
    end else if (code_q < StTempFirst) begin
      rel = code_q - StTempSum;
      ch = (rel >= 5'd6) ? 2'd2 : (rel >= 5'd3) ? 2'd1 : 2'd0;
      rel = rel - 5'(3 * ch);
      vld_o = cnt_q[ch] != '0;
      case (rel)
        5'd0: val_o = 64'(snap_q.acc[ch].sum);
        5'd1: val_o = {24'd0, snap_q.acc[ch].sq};
        default: begin
          val_o = 64'(cnt_q[ch]);
          vld_o = 1'b1;
        end
      endcase
    end else if (code_q < StPoints) begin
      rel = code_q - StTempFirst;
      ch = 2'(rel >> 1);
      vld_o = snap_q.acc[ch].first_v;
      if (vld_o) val_o = rel[0] ? 64'(snap_q.acc[ch].last_val) : 64'(snap_q.acc[ch].first);
    end else begin
      val_o = 64'(pts_q);
      vld_o = 1'b1;
    end
  end

  assign busy_o = busy_q;
  assign sv_o = busy_q;
  assign code_o = code_q;
  assign last_o = code_q == StPoints;

endmodule

// ----- rtl/wdmm_checker.sv -----
module wdmm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        kind_o,
  input logic [4:0]  stat_code_o,
  input logic        last_o,
  input logic        stat_valid_o,
  input logic        curve_one_valid_o
);
  import wdmm_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("output word dropped");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> kind_o && stat_code_o == StPoints)
    else $error("last flag on wrong word");
  a_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o && !out_stall_i && !last_o |=> out_valid_o)
    else $error("statistics run broken");
  a_pt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !kind_o |-> !stat_valid_o && stat_code_o == 5'd0)
    else $error("point carries statistic");
  a_st: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o |-> !curve_one_valid_o) else $error("statistic carries curve");

endmodule

bind windowed_decimating_min_max_stats wdmm_checker u_wdmm_checker (.*);

// ----- tb/windowed_decimating_min_max_stats_checker.sv -----
module windowed_decimating_min_max_stats_checker
  import wdmm_pkg::*;
#(
  parameter int unsigned POINT_CAPACITY = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               mode_i,
  input  logic [31:0]        timestamp_i,
  input  logic signed [15:0] temp_code_i,
  input  logic signed [15:0] hum_code_i,
  input  logic signed [15:0] press_code_i,
  input  logic               hum_present_i,
  input  logic               press_present_i,
  input  logic               is_newest_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               kind_i,
  input  logic [7:0]         point_index_i,
  input  logic [31:0]        point_time_i,
  input  logic signed [15:0] curve_one_i,
  input  logic               curve_one_valid_i,
  input  logic signed [15:0] curve_two_i,
  input  logic               curve_two_valid_i,
  input  logic [4:0]         stat_code_i,
  input  logic signed [63:0] stat_value_i,
  input  logic               stat_valid_i,
  input  logic               last_i,
  output int                 errors_o,
  output int                 pending_o,
  output int                 points_seen_o,
  output int                 stats_seen_o
);

  typedef struct packed {
    logic               kind;
    logic [7:0]         idx;
    logic [31:0]        t;
    logic signed [15:0] c1;
    logic               c1v;
    logic signed [15:0] c2;
    logic               c2v;
    logic [4:0]         code;
    logic signed [63:0] val;
    logic               sv;
    logic               last;
  } word_t;

  word_t expected_words[$];

  logic [31:0] win_lo, win_hi;
  logic [5:0]  decim;
  logic [1:0]  curve_sel;
  logic        press_on;
  logic signed [15:0] missing;

  int unsigned phase, npoints;
  logic signed [15:0] xv[8];
  logic        xok[8];
  logic [31:0] xt[8];
  logic [7:0]  mn_idx, mx_idx;
  logic signed [63:0] sums[3];
  logic [40:0] sqs[3];
  int unsigned cnts[3];
  logic signed [15:0] flv[6];
  logic        flok[6];

  function automatic int unsigned eff_decim();
    return (decim == 0) ? 1 : decim;
  endfunction

  function automatic void clear_stats();
    phase = eff_decim() - 1;
    npoints = 0;
    mn_idx = 0;
    mx_idx = 0;
    for (int k = 0; k < 8; k++) begin
      xv[k] = 0; xok[k] = 0; xt[k] = 0;
    end
    for (int k = 0; k < 3; k++) begin
      sums[k] = 0; sqs[k] = 0; cnts[k] = 0;
    end
    for (int k = 0; k < 6; k++) begin
      flv[k] = 0; flok[k] = 0;
    end
  endfunction

  function automatic int track_extreme(int k, logic signed [15:0] v, logic [31:0] t);
    int r;
    r = 0;
    if (!xok[k] || v < xv[k]) begin
      xv[k] = v; xt[k] = t; xok[k] = 1; r |= 1;
    end
    if (!xok[k+1] || v > xv[k+1]) begin
      xv[k+1] = v; xt[k+1] = t; xok[k+1] = 1; r |= 2;
    end
    return r;
  endfunction

  function automatic void add_to_channel(int ch, logic signed [15:0] v);
    logic [40:0] sq;
    sq = 41'(int'(v) * int'(v));
    sums[ch] += 64'(v);
    sqs[ch] = (sqs[ch] + sq > 41'(SqMax)) ? 41'(SqMax) : sqs[ch] + sq;
    cnts[ch]++;
    if (!flok[2*ch]) begin
      flv[2*ch] = v; flok[2*ch] = 1;
    end
    flv[2*ch+1] = v;
    flok[2*ch+1] = 1;
  endfunction

  function automatic word_t stat_word(int code, logic [7:0] idx, logic [31:0] t,
                                      logic signed [63:0] val, logic ok);
    word_t w;
    w = '0;
    w.kind = 1; w.idx = idx; w.t = t; w.code = 5'(code);
    w.val = val; w.sv = ok; w.last = (code == StPoints);
    return w;
  endfunction

  function automatic void emit_stats();
    for (int k = 0; k < 8; k++)
      expected_words.push_back(stat_word(k, (k == StPlotTempMin) ? mn_idx :
          (k == StPlotTempMax) ? mx_idx : 8'd0, xt[k], xok[k] ? 64'(xv[k]) : 64'd0, xok[k]));
    for (int ch = 0; ch < 3; ch++) begin
      expected_words.push_back(stat_word(StTempSum + 3*ch, 0, 0, sums[ch], cnts[ch] != 0));
      expected_words.push_back(stat_word(StTempSq + 3*ch, 0, 0, 64'(sqs[ch]),
                                         cnts[ch] != 0));
      expected_words.push_back(stat_word(StTempCnt + 3*ch, 0, 0, 64'(cnts[ch]), 1));
    end
    for (int k = 0; k < 6; k++)
      expected_words.push_back(stat_word(StTempFirst + k, 0, 0,
                                         flok[k] ? 64'(flv[k]) : 64'd0, flok[k]));
    expected_words.push_back(stat_word(StPoints, 0, 0, 64'(npoints), 1));
    clear_stats();
  endfunction

  function automatic void take_record(logic [31:0] t, logic signed [15:0] tv,
                                      logic signed [15:0] hv, logic signed [15:0] pv,
                                      logic hp, logic pp, logic newest);
    logic tok, hok, pok, c2ok, pick;
    logic signed [15:0] c2;
    int r;
    word_t w;
    if (t < win_lo || t > win_hi) return;
    if (npoints >= POINT_CAPACITY) return;
    tok = tv != missing;
    hok = hp && hv != missing;
    pok = pp && pv != missing;
    if (tok) void'(track_extreme(0, tv, t));
    if (pok) void'(track_extreme(2, pv, t));
    if (phase + 1 >= eff_decim()) begin
      phase = 0; pick = 1;
    end else begin
      phase++; pick = 0;
    end
    if (newest) pick = 1;
    if (!pick) return;
    c2 = 0;
    c2ok = 0;
    if (curve_sel == CurveHum) begin
      c2 = hok ? hv : 16'sd0; c2ok = hok;
    end else if (curve_sel == CurvePress) begin
      c2 = pok ? pv : 16'sd0; c2ok = pok;
    end
    if (tok) begin
      r = track_extreme(4, tv, t);
      if (r & 1) mn_idx = 8'(npoints);
      if (r & 2) mx_idx = 8'(npoints);
      add_to_channel(0, tv);
    end
    if (c2ok) void'(track_extreme(6, c2, t));
    if (curve_sel == CurveHum && hok) add_to_channel(1, hv);
    if (press_on && pok) add_to_channel(2, pv);
    w = '0;
    w.idx = 8'(npoints); w.t = t; w.c1 = tok ? tv : 16'sd0; w.c1v = tok;
    w.c2 = c2; w.c2v = c2ok;
    expected_words.push_back(w);
    npoints++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    word_t w;
    if (!rst_ni) begin
      win_lo = 0; win_hi = '1; decim = 1; curve_sel = 0; press_on = 0;
      missing = -16'sd32768;
      clear_stats();
      expected_words.delete();
      errors_o = 0;
      points_seen_o = 0;
      stats_seen_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          $error("unexpected output word kind=%0d", kind_i);
          errors_o++;
        end else begin
          w = expected_words.pop_front();
          if (kind_i) stats_seen_o++; else points_seen_o++;
          if (kind_i !== w.kind) begin
            $error("kind exp %0d got %0d", w.kind, kind_i); errors_o++;
          end
          if (point_index_i !== w.idx) begin
            $error("point_index exp %0d got %0d", w.idx, point_index_i); errors_o++;
          end
          if (point_time_i !== w.t) begin
            $error("point_time exp %0d got %0d", w.t, point_time_i); errors_o++;
          end
          if (curve_one_i !== w.c1) begin
            $error("curve_one exp %0d got %0d", w.c1, curve_one_i); errors_o++;
          end
          if (curve_one_valid_i !== w.c1v) begin
            $error("curve_one_valid exp %0d got %0d", w.c1v, curve_one_valid_i);
            errors_o++;
          end
          if (curve_two_i !== w.c2) begin
            $error("curve_two exp %0d got %0d", w.c2, curve_two_i); errors_o++;
          end
          if (curve_two_valid_i !== w.c2v) begin
            $error("curve_two_valid exp %0d got %0d", w.c2v, curve_two_valid_i);
            errors_o++;
          end
          if (stat_code_i !== w.code) begin
            $error("stat_code exp %0d got %0d", w.code, stat_code_i); errors_o++;
          end
          if (stat_value_i !== w.val) begin
            $error("stat_value exp %0d got %0d", w.val, stat_value_i); errors_o++;
          end
          if (stat_valid_i !== w.sv) begin
            $error("stat_valid exp %0d got %0d", w.sv, stat_valid_i); errors_o++;
          end
          if (last_i !== w.last) begin
            $error("last exp %0d got %0d", w.last, last_i); errors_o++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegWinStart: win_lo = cfg_data_i;
          RegWinEnd:   win_hi = cfg_data_i;
          RegDecim: begin
            decim = cfg_data_i[5:0];
            phase = eff_decim() - 1;
          end
          RegCurve:    curve_sel = cfg_data_i[1:0];
          RegPressOn:  press_on = cfg_data_i[0];
          RegMissing:  missing = cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (mode_i) emit_stats();
        else take_record(timestamp_i, temp_code_i, hum_code_i, press_code_i,
                         hum_present_i, press_present_i, is_newest_i);
      end
    end
    pending_o = expected_words.size();
  end

endmodule

// ----- tb/windowed_decimating_min_max_stats_tb.sv -----
module windowed_decimating_min_max_stats_tb;
  import wdmm_pkg::*;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [2:0] cfg_index_i = 0;
  logic [31:0] cfg_data_i = 0;
  logic in_valid_i = 0;
  logic in_stall_o;
  logic mode_i = 0;
  logic [31:0] timestamp_i = 0;
  logic signed [15:0] temp_code_i = 0, hum_code_i = 0, press_code_i = 0;
  logic hum_present_i = 0, press_present_i = 0, is_newest_i = 0;
  logic out_valid_o;
  logic out_stall_i = 0;
  logic kind_o, curve_one_valid_o, curve_two_valid_o, stat_valid_o, last_o;
  logic [7:0] point_index_o;
  logic [31:0] point_time_o;
  logic signed [15:0] curve_one_o, curve_two_o;
  logic [4:0] stat_code_o;
  logic signed [63:0] stat_value_o;
  int errors, pending, points_seen, stats_seen;
  int burst_left;
  logic [31:0] base_time;
  bit stall_hold = 0;

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  windowed_decimating_min_max_stats dut (.*);

  windowed_decimating_min_max_stats_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .mode_i, .timestamp_i, .temp_code_i,
    .hum_code_i, .press_code_i, .hum_present_i, .press_present_i, .is_newest_i,
    .out_valid_i(out_valid_o), .out_stall_i, .kind_i(kind_o),
    .point_index_i(point_index_o), .point_time_i(point_time_o),
    .curve_one_i(curve_one_o), .curve_one_valid_i(curve_one_valid_o),
    .curve_two_i(curve_two_o), .curve_two_valid_i(curve_two_valid_o),
    .stat_code_i(stat_code_o), .stat_value_i(stat_value_o), .stat_valid_i(stat_valid_o),
    .last_i(last_o), .errors_o(errors), .pending_o(pending),
    .points_seen_o(points_seen), .stats_seen_o(stats_seen)
  );

  // Receiver stall pattern: long clean stretches alternate with random stalls.
  always @(posedge clk_i) begin
    if (($urandom % 64) == 0) stall_hold <= !stall_hold;
    out_stall_i <= stall_hold ? 1'b0 : (($urandom % 3) == 0);
  end

  // Registers are written only once the block has gone quiet.
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    in_valid_i <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  // Sends one word; valid stays high across back-to-back words within a burst.
  task automatic send_word(logic md, logic [31:0] t, logic signed [15:0] tv,
                           logic signed [15:0] hv, logic signed [15:0] pv,
                           logic hp, logic pp, logic nw);
    if (burst_left == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
      burst_left = ($urandom % 4 == 0) ? 40 : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid_i <= 1;
    mode_i <= md; timestamp_i <= t; temp_code_i <= tv; hum_code_i <= hv;
    press_code_i <= pv; hum_present_i <= hp; press_present_i <= pp; is_newest_i <= nw;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic idle_and_drain();
    int guard;
    guard = 0;
    in_valid_i <= 0;
    @(posedge clk_i);
    while (pending != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (40) @(posedge clk_i);
  endtask

  task automatic random_record(int mostly_in);
    logic [31:0] t;
    logic signed [15:0] tv, hv, pv;
    t = base_time + $urandom_range(0, 200);
    if (!mostly_in && $urandom % 4 == 0) t = $urandom;
    tv = ($urandom % 8 == 0) ? 16'sh8000 : 16'($urandom);
    hv = ($urandom % 8 == 0) ? 16'sh8000 : 16'($urandom);
    pv = ($urandom % 8 == 0) ? 16'sh8000 : 16'($urandom);
    if ($urandom % 3 == 0) tv = 16'($signed($urandom_range(0, 200)) - 100);
    send_word(0, t, tv, hv, pv, 1'($urandom), 1'($urandom), ($urandom % 10) == 0);
  endtask

  initial begin
    #400000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    burst_left = 0;
    base_time = 1000;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: extremes, missing codes, ties, newest flag, finish on empty state.
    send_word(1, 0, 0, 0, 0, 0, 0, 0);
    write_reg(RegCurve, 1);
    write_reg(RegPressOn, 1);
    send_word(0, 0, 16'sh7fff, 16'sh8000, 16'sh7fff, 1, 1, 0);
    send_word(0, 32'hffffffff, 16'sh8000, 16'sh7fff, 16'sh8000, 1, 1, 0);
    send_word(0, 5, 16'sh8001, 16'sh8001, 16'sh8001, 0, 0, 1);
    send_word(0, 6, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1, 1, 0);
    send_word(0, 7, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1, 1, 0);
    send_word(0, 8, -16'sd1, 0, -16'sd1, 1, 0, 1);
    send_word(1, 9, 0, 0, 0, 0, 0, 0);
    idle_and_drain();
    write_reg(RegMissing, 32'h0000_0000);
    write_reg(RegCurve, 2);
    write_reg(RegDecim, 0);
    send_word(0, 10, 0, 0, 0, 1, 1, 0);
    send_word(0, 11, 16'sh8000, 16'sh8000, 16'sh8000, 1, 1, 0);
    write_reg(RegDecim, 3);
    idle_and_drain();
    write_reg(RegCurve, 3);
    write_reg(RegWinStart, 100);
    write_reg(RegWinEnd, 50);
    send_word(0, 75, 5, 5, 5, 1, 1, 1);
    send_word(0, 100, 5, 5, 5, 1, 1, 1);
    send_word(1, 0, 0, 0, 0, 0, 0, 0);
    idle_and_drain();
    write_reg(RegWinStart, 10);
    write_reg(RegWinEnd, 20);
    send_word(0, 9, 1, 1, 1, 1, 1, 1);
    send_word(0, 10, 2, 2, 2, 1, 1, 0);
    send_word(0, 20, 3, 3, 3, 1, 1, 0);
    send_word(0, 21, 4, 4, 4, 1, 1, 1);
    send_word(1, 0, 0, 0, 0, 0, 0, 0);
    idle_and_drain();
    write_reg(3'd7, 32'hdeadbeef);
    write_reg(RegMissing, 32'h0000_8000);

    // Random phases through a spread of settings.
    for (int ph = 0; ph < 6; ph++) begin
      int decs[6] = '{1, 2, 4, 8, 51, 63};
      base_time = $urandom;
      if (base_time > 32'hffff_fe00) base_time = 32'hffff_fe00;
      write_reg(RegDecim, decs[ph]);
      write_reg(RegCurve, ph % 3);
      write_reg(RegPressOn, ph[0]);
      write_reg(RegWinStart, (ph == 5) ? 0 : base_time + 20);
      write_reg(RegWinEnd, (ph == 5) ? 32'hffffffff : base_time + 180);
      write_reg(RegMissing, (ph == 3) ? 32'h0000_7fff : 32'h0000_8000);
      for (int n = 0; n < 18; n++) begin
        if (n % 9 == 8) send_word(1, 0, 0, 0, 0, 0, 0, 0);
        else random_record(ph != 4);
      end
      idle_and_drain();
    end

    $display("checked %0d plot points and %0d statistic words", points_seen, stats_seen);
    $display("settings covered decimation 0..63, all curves, windows and missing codes");
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
